>>> src/gds_pkg.sv
// Package for the Gregorian date step block: month codes, reciprocal constants
// for the divide-by-25 in the leap test, and the month length tables.
// No dependencies; every other file of the block uses it.
package gds_pkg;

  // Default year width; the top level takes it as its parameter default.
  localparam int unsigned YearBitsDefault = 14;

  // Month codes that the calendar logic treats specially.
  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  // Day counts that the stepping logic uses.
  localparam logic [4:0] DayFirst   = 5'd1;
  localparam logic [4:0] DayJanLast = 5'd31;
  localparam logic [4:0] DayFebLeap = 5'd29;

  // x / 25 is taken as (x * RecipMul) >> RecipShift. The rounding error of
  // RecipMul times any x below 43690 stays under one unit, which covers the
  // quarter-year value for every year width up to 16 bits.
  localparam int unsigned RecipBits  = 16;
  localparam int unsigned RecipShift = 20;
  localparam logic [RecipBits-1:0] RecipMul = 16'd41944;
  localparam int unsigned CenturyQuarters = 25;

  // Length of month m in a year whose leap flag is leap.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? DayFebLeap : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days of a common year that come before the first of month m.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] days;
    unique case (m)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

>>> src/gds_leap.sv
// Leap-year pipeline of the date step block: two register stages that carry
// the date along and produce the Gregorian leap flag. Uses gds_pkg.
module gds_leap #(
  parameter int unsigned YEAR_BITS = gds_pkg::YearBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [4:0]           day_i,
  input  logic [3:0]           month_i,
  input  logic [YEAR_BITS-1:0] year_i,
  output logic                 valid_o,
  output logic [4:0]           day_o,
  output logic [3:0]           month_o,
  output logic [YEAR_BITS-1:0] year_o,
  output logic                 leap_o
);

  localparam int unsigned QBits    = YEAR_BITS - 2;
  localparam int unsigned ProdBits = QBits + gds_pkg::RecipBits;

  // Stage one: multiply the quarter-year by the reciprocal of 25.
  logic                 valid1_q;
  logic [4:0]           day1_q;
  logic [3:0]           month1_q;
  logic [YEAR_BITS-1:0] year1_q;
  logic [ProdBits-1:0]  prod1_d, prod1_q;

  assign prod1_d = ProdBits'(year_i[YEAR_BITS-1:2]) * ProdBits'(gds_pkg::RecipMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    day1_q   <= day_i;
    month1_q <= month_i;
    year1_q  <= year_i;
    prod1_q  <= prod1_d;
  end

  // Stage two: remainder of the quarter-year by 25, then the leap rule.
  // A year is a century when its quarter is a multiple of 25, and a
  // century is a leap year when its quarter is also a multiple of four.
  logic [QBits-1:0] quarter, quot, quot25, rem25;
  logic             leap_d, valid2_q, leap2_q;
  logic [4:0]       day2_q;
  logic [3:0]       month2_q;
  logic [YEAR_BITS-1:0] year2_q;

  assign quarter = year1_q[YEAR_BITS-1:2];
  assign quot    = QBits'(prod1_q >> gds_pkg::RecipShift);
  assign quot25  = QBits'(quot * QBits'(gds_pkg::CenturyQuarters));
  assign rem25   = quarter - quot25;
  assign leap_d  = (year1_q[1:0] == 2'b00) &&
                   ((rem25 != '0) || (year1_q[3:2] == 2'b00));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    day2_q   <= day1_q;
    month2_q <= month1_q;
    year2_q  <= year1_q;
    leap2_q  <= leap_d;
  end

  assign valid_o = valid2_q;
  assign day_o   = day2_q;
  assign month_o = month2_q;
  assign year_o  = year2_q;
  assign leap_o  = leap2_q;

endmodule

>>> src/gds_step.sv
// Calendar step pipeline of the date step block: validity, month lengths and
// day-of-year base in one stage, next and previous dates in the next. Uses gds_pkg.
module gds_step #(
  parameter int unsigned YEAR_BITS = gds_pkg::YearBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [4:0]           day_i,
  input  logic [3:0]           month_i,
  input  logic [YEAR_BITS-1:0] year_i,
  input  logic                 leap_i,
  output logic                 valid_o,
  output logic                 is_valid_o,
  output logic                 is_leap_o,
  output logic [4:0]           next_day_o,
  output logic [3:0]           next_month_o,
  output logic [YEAR_BITS-1:0] next_year_o,
  output logic [4:0]           prev_day_o,
  output logic [3:0]           prev_month_o,
  output logic [YEAR_BITS-1:0] prev_year_o,
  output logic [8:0]           day_of_year_o
);

  // Stage three: month lengths, validity and the day-of-year base.
  logic       month_ok, ok_d, last_d;
  logic [4:0] len, prev_len_d;
  logic [3:0] prev_month_d;
  logic [8:0] base_d;

  assign month_ok     = (month_i >= gds_pkg::MonthJan) && (month_i <= gds_pkg::MonthDec);
  assign len          = gds_pkg::month_len(month_i, leap_i);
  assign ok_d         = month_ok && (year_i != '0) && (day_i != 5'd0) && (day_i <= len);
  assign last_d       = (day_i == len);
  assign prev_month_d = (month_i == gds_pkg::MonthJan) ? gds_pkg::MonthDec
                                                       : month_i - 4'd1;
  assign prev_len_d   = gds_pkg::month_len(prev_month_d, leap_i);
  assign base_d       = gds_pkg::days_before(month_i) +
                        9'((leap_i && (month_i > gds_pkg::MonthFeb)) ? 1 : 0);

  logic                 valid3_q, ok3_q, leap3_q, last3_q;
  logic [4:0]           day3_q, prev_len3_q;
  logic [3:0]           month3_q, prev_month3_q;
  logic [YEAR_BITS-1:0] year3_q;
  logic [8:0]           base3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ok3_q         <= ok_d;
    leap3_q       <= leap_i;
    last3_q       <= last_d;
    day3_q        <= day_i;
    month3_q      <= month_i;
    year3_q       <= year_i;
    prev_month3_q <= prev_month_d;
    prev_len3_q   <= prev_len_d;
    base3_q       <= base_d;
  end

  // Stage four: step forward and back; an invalid date repeats itself.
  logic [4:0]           nd_d, pd_d;
  logic [3:0]           nm_d, pm_d;
  logic [YEAR_BITS-1:0] ny_d, py_d;
  logic [8:0]           doy_d;

  always_comb begin
    nd_d  = day3_q;
    nm_d  = month3_q;
    ny_d  = year3_q;
    pd_d  = day3_q;
    pm_d  = month3_q;
    py_d  = year3_q;
    doy_d = 9'd0;
    if (ok3_q) begin
      // Following date: roll over at the end of a month and of the year.
      if (last3_q) begin
        nd_d = gds_pkg::DayFirst;
        if (month3_q == gds_pkg::MonthDec) begin
          nm_d = gds_pkg::MonthJan;
          ny_d = year3_q + YEAR_BITS'(1);
        end else begin
          nm_d = month3_q + 4'd1;
        end
      end else begin
        nd_d = day3_q + 5'd1;
      end
      // Preceding date: fall back to the end of the prior month or year.
      if (day3_q == gds_pkg::DayFirst) begin
        pm_d = prev_month3_q;
        if (month3_q == gds_pkg::MonthJan) begin
          pd_d = gds_pkg::DayJanLast;
          py_d = year3_q - YEAR_BITS'(1);
        end else begin
          pd_d = prev_len3_q;
        end
      end else begin
        pd_d = day3_q - 5'd1;
      end
      doy_d = base3_q + 9'(day3_q);
    end
  end

  logic                 valid4_q, ok4_q, leap4_q;
  logic [4:0]           nd4_q, pd4_q;
  logic [3:0]           nm4_q, pm4_q;
  logic [YEAR_BITS-1:0] ny4_q, py4_q;
  logic [8:0]           doy4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
    end else begin
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok4_q   <= ok3_q;
    leap4_q <= leap3_q;
    nd4_q   <= nd_d;
    nm4_q   <= nm_d;
    ny4_q   <= ny_d;
    pd4_q   <= pd_d;
    pm4_q   <= pm_d;
    py4_q   <= py_d;
    doy4_q  <= doy_d;
  end

  assign valid_o       = valid4_q;
  assign is_valid_o    = ok4_q;
  assign is_leap_o     = leap4_q;
  assign next_day_o    = nd4_q;
  assign next_month_o  = nm4_q;
  assign next_year_o   = ny4_q;
  assign prev_day_o    = pd4_q;
  assign prev_month_o  = pm4_q;
  assign prev_year_o   = py4_q;
  assign day_of_year_o = doy4_q;

endmodule

>>> src/gregorian_date_step.sv
// Top level of the Gregorian date step block: leap pipeline followed by the
// calendar step pipeline. Depends on gds_pkg, gds_leap and gds_step.
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ---------------------------------------
//   command   start_i, busy_o (input)    day_in_i, month_in_i, year_in_i
//   result    done_o (output strobe)     is_valid_o, is_leap_o, next_*, prev_*,
//                                        day_of_year_o
//
// One beat is accepted every cycle; busy_o stays low. Each result comes out
// as a one-cycle done_o strobe, in order, once its beat has passed every stage.
// The four stages are the reciprocal multiply, the leap rule, the month length
// and validity lookup, and the next and previous date step.
// Reset clears only the stage valid bits. The receiver cannot stall the
// pipeline, so results never wait and none is held back.
module gregorian_date_step #(
  parameter int unsigned YEAR_BITS = gds_pkg::YearBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [4:0]           day_in_i,
  input  logic [3:0]           month_in_i,
  input  logic [YEAR_BITS-1:0] year_in_i,
  output logic                 done_o,
  output logic                 is_valid_o,
  output logic                 is_leap_o,
  output logic [4:0]           next_day_o,
  output logic [3:0]           next_month_o,
  output logic [YEAR_BITS-1:0] next_year_o,
  output logic [4:0]           prev_day_o,
  output logic [3:0]           prev_month_o,
  output logic [YEAR_BITS-1:0] prev_year_o,
  output logic [8:0]           day_of_year_o
);

  // The pipeline takes a beat in every cycle.
  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic                 lp_valid, lp_leap;
  logic [4:0]           lp_day;
  logic [3:0]           lp_month;
  logic [YEAR_BITS-1:0] lp_year;

  // Leap flag of the input year.
  gds_leap #(
    .YEAR_BITS(YEAR_BITS)
  ) u_leap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .day_i   (day_in_i),
    .month_i (month_in_i),
    .year_i  (year_in_i),
    .valid_o (lp_valid),
    .day_o   (lp_day),
    .month_o (lp_month),
    .year_o  (lp_year),
    .leap_o  (lp_leap)
  );

  // Validity, neighbor dates and day of year.
  gds_step #(
    .YEAR_BITS(YEAR_BITS)
  ) u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (lp_valid),
    .day_i         (lp_day),
    .month_i       (lp_month),
    .year_i        (lp_year),
    .leap_i        (lp_leap),
    .valid_o       (done_o),
    .is_valid_o    (is_valid_o),
    .is_leap_o     (is_leap_o),
    .next_day_o    (next_day_o),
    .next_month_o  (next_month_o),
    .next_year_o   (next_year_o),
    .prev_day_o    (prev_day_o),
    .prev_month_o  (prev_month_o),
    .prev_year_o   (prev_year_o),
    .day_of_year_o (day_of_year_o)
  );

endmodule
